/* rtl/core/assert_macros.svh */
// Assertion macros shared by the core RTL files.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// Next-cycle implication, checked during reset as well.
`define ASSERT_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

/* rtl/core/pn4d_pkg.sv */
// Package for the 4D Perlin noise core: widths, request types, gradient function.
// Depends on nothing; imported by every module of the core.
package pn4d_pkg;

    // Table and fraction geometry.
    localparam int TAB_BITS      = 8;
    localparam int TABLE_ENTRIES = 1 << TAB_BITS;
    localparam int FRAC_BITS     = 16;
    localparam int COORD_W       = 32;
    localparam int SCALE_W       = 24;
    localparam int OUT_W         = 19;
    localparam int PROD_W        = COORD_W + SCALE_W + 1;

    // Request type codes.
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_EVAL = 1'b1;

    // Queue between front and back.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // Fade datapath widths.
    localparam int A_W    = FRAC_BITS + 5;
    localparam int TA_W   = FRAC_BITS + 1 + A_W;
    localparam int B_W    = FRAC_BITS + 5;
    localparam int FADE_W = FRAC_BITS + 2;

    // Dot product and blend widths.
    localparam int D_W    = FRAC_BITS + 2;
    localparam int VAL_W  = FRAC_BITS + 5;
    localparam int DIFF_W = VAL_W + 1;
    localparam int LP_W   = FADE_W + DIFF_W;

    localparam logic signed [A_W-1:0] C15 = A_W'(15 * (1 << FRAC_BITS));
    localparam logic signed [B_W-1:0] C10 = B_W'(10 * (1 << FRAC_BITS));
    localparam logic signed [D_W-1:0] C1  = D_W'(1 << FRAC_BITS);

    // Output limits, Q2.16.
    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    // One request as it moves from the front to the back.
    typedef struct packed {
        logic                          is_eval;
        logic [7:0]                    idx;
        logic [7:0]                    tval;
        logic [3:0][COORD_W-1:0]       coord;
    } t_req;

    // Queue status seen by the front and the top level.
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // Gradient component k of gradient h: bits 4:3 pick the zero axis, and
    // bits 2:0 give the signs of the other three axes in order (set = -1).
    function automatic logic signed [1:0] grad_comp(input logic [4:0] h,
                                                    input logic [1:0] k);
        logic [1:0] z;
        logic [1:0] pos;
        logic       neg;
        z   = h[4:3];
        pos = (k < z) ? k : k - 2'd1;
        neg = h[2'd2 - pos];
        if (k == z) begin
            return 2'sd0;
        end
        return neg ? -2'sd1 : 2'sd1;
    endfunction

endpackage

/* rtl/core/pn4d_front.sv */
// Front stage of the 4D Perlin noise core: accepts and classifies requests.
// Depends on pn4d_pkg; feeds pn4d_queue.
module pn4d_front
    import pn4d_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_req_type,
    input  logic [7:0]         i_table_index,
    input  logic [7:0]         i_table_value,
    input  logic signed [31:0] i_coord_x,
    input  logic signed [31:0] i_coord_y,
    input  logic signed [31:0] i_coord_z,
    input  logic signed [31:0] i_coord_w,
    input  t_qstat             i_qstat,
    output logic               o_push,
    output t_req               o_req
);

    logic r_valid;
    t_req r_req;
    logic n_valid;
    logic w_accept;

    // A held request blocks new ones only while the queue is full.
    assign busy     = r_valid && i_qstat.full;
    assign w_accept = start && !busy;
    assign o_push   = r_valid && !i_qstat.full;
    assign o_req    = r_req;

    always_comb begin
        n_valid = w_accept || (r_valid && i_qstat.full);
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Classify and capture the request.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req.is_eval  <= (i_req_type == REQ_EVAL);
            r_req.idx      <= i_table_index;
            r_req.tval     <= i_table_value;
            r_req.coord[0] <= i_coord_x;
            r_req.coord[1] <= i_coord_y;
            r_req.coord[2] <= i_coord_z;
            r_req.coord[3] <= i_coord_w;
        end
    end

endmodule

/* rtl/core/pn4d_queue.sv */
// Short request queue between the front and back of the noise core.
// Depends on pn4d_pkg.
module pn4d_queue
    import pn4d_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_req   i_req,
    input  logic   i_pop,
    output t_req   o_req,
    output t_qstat o_stat
);

    t_req              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_count;
    logic              w_push;
    logic              w_pop;

    assign o_stat.full  = (r_count == (QPTR_W+1)'(QDEPTH));
    assign o_stat.empty = (r_count == '0);
    assign w_push       = i_push && !o_stat.full;
    assign w_pop        = i_pop && !o_stat.empty;
    assign o_req        = r_mem[r_rd];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_req;
        end
    end

endmodule

/* rtl/core/pn4d_back.sv */
// Back pipeline of the noise core: scaling, fade, table hashing, dot, blends.
// Depends on pn4d_pkg; holds the replicated permutation table banks.
module pn4d_back
    import pn4d_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  t_req                    i_req,
    input  logic [SCALE_W-1:0]      i_scale,
    output logic                    o_valid,
    output logic signed [OUT_W-1:0] o_noise_value
);

    localparam int NBANK = 15;
    localparam int NRD   = 2 * NBANK;
    localparam int RND_SH = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
    localparam int UP_SH  = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
    localparam int CV_W   = VAL_W + 8;

    // Stage 1: scaled coordinates and request fields.
    logic                     r_ev1;
    logic signed [PROD_W-1:0] r_prod [4];
    logic [1:4]               r_ld;
    logic [7:0]               r_idx [1:4];
    logic [7:0]               r_tv  [1:4];
    logic [2:4]               r_ev;

    // Fade pipeline, stages 2 to 5.
    logic [FRAC_BITS-1:0]     w_frac [4];
    logic [FRAC_BITS-1:0]     r_fr2 [4];
    logic [FRAC_BITS-1:0]     r_fr3 [4];
    logic [FRAC_BITS-1:0]     r_fr4 [4];
    logic [FRAC_BITS-1:0]     r_fr5 [4];
    logic [2*FRAC_BITS-1:0]   r_tt  [4];
    logic signed [A_W-1:0]    r_a   [4];
    logic signed [TA_W-1:0]   r_ta  [4];
    logic [2*FRAC_BITS-1:0]   r_t2t [4];
    logic signed [B_W-1:0]    r_b   [4];
    logic [FRAC_BITS-1:0]     r_t3  [4];
    logic signed [FADE_W-1:0] r_fd5 [4];
    logic signed [FADE_W-1:0] r_fd6 [4];
    logic                     r_ev5;
    logic                     r_ev6;

    // Cell indexes for the hash levels.
    logic [TAB_BITS-1:0]      w_lcell [4];
    logic [TAB_BITS-1:0]      r_cell2 [3];
    logic [TAB_BITS-1:0]      r_cell3 [2];
    logic [TAB_BITS-1:0]      r_cell4;

    // Table banks and registered read data.
    logic [7:0]               r_bank [NBANK][TABLE_ENTRIES];
    logic [7:0]               r_hd   [NRD];
    logic [TAB_BITS-1:0]      w_addr [NRD];
    logic [3:0]               w_we;
    logic [TAB_BITS-1:0]      w_widx [4];
    logic [7:0]               w_wval [4];

    // Corner values and blend levels.
    logic signed [VAL_W-1:0]  w_dot [16];
    logic signed [VAL_W-1:0]  r_val [16];
    logic signed [VAL_W-1:0]  w_lin [4][16];
    logic signed [DIFF_W-1:0] r_dif [4][8];
    logic signed [VAL_W-1:0]  r_lo1 [4][8];
    logic signed [LP_W-1:0]   r_prd [4][8];
    logic signed [VAL_W-1:0]  r_lo2 [4][8];
    logic signed [VAL_W-1:0]  r_res [4][8];
    logic signed [FADE_W-1:0] r_fa  [4][4];
    logic signed [FADE_W-1:0] r_fb  [4][4];
    logic signed [FADE_W-1:0] r_fc  [4][4];
    logic [3:0]               r_va;
    logic [3:0]               r_vb;
    logic [3:0]               r_vc;

    // Output.
    logic signed [CV_W-1:0]   w_cv;
    logic signed [OUT_W-1:0]  w_sat;
    logic                     r_out_valid;
    logic signed [OUT_W-1:0]  r_out;

    // Valid chain for all stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev1       <= 1'b0;
            r_ld        <= '0;
            r_ev        <= '0;
            r_ev5       <= 1'b0;
            r_ev6       <= 1'b0;
            r_va        <= '0;
            r_vb        <= '0;
            r_vc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_ev1       <= i_valid && i_req.is_eval;
            r_ld[1]     <= i_valid && !i_req.is_eval;
            r_ld[2:4]   <= r_ld[1:3];
            r_ev[2]     <= r_ev1;
            r_ev[3:4]   <= r_ev[2:3];
            r_ev5       <= r_ev[4];
            r_ev6       <= r_ev5;
            r_va[0]     <= r_ev6;
            r_va[3:1]   <= r_vc[2:0];
            r_vb        <= r_va;
            r_vc        <= r_vb;
            r_out_valid <= r_vc[3];
        end
    end

    // Stage 1: scale coordinates, capture load fields.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            r_prod[k] <= PROD_W'($signed(i_req.coord[k]) * $signed({1'b0, i_scale}));
        end
        r_idx[1] <= i_req.idx;
        r_tv[1]  <= i_req.tval;
        for (int s = 2; s <= 4; s++) begin
            r_idx[s] <= r_idx[s-1];
            r_tv[s]  <= r_tv[s-1];
        end
    end

    // Lattice cell and fraction from the scaled coordinate.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_frac[k] = r_prod[k][31 -: FRAC_BITS];
        end
        w_lcell[0] = r_prod[3][32 +: TAB_BITS];
        w_lcell[1] = r_cell2[2];
        w_lcell[2] = r_cell3[1];
        w_lcell[3] = r_cell4;
    end

    // Fade 6t^5 - 15t^4 + 10t^3 over four stages.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            r_fr2[k] <= w_frac[k];
            r_tt[k]  <= w_frac[k] * w_frac[k];
            r_a[k]   <= ($signed({5'b0, w_frac[k]}) <<< 2)
                      + ($signed({5'b0, w_frac[k]}) <<< 1) - C15;
            r_fr3[k] <= r_fr2[k];
            r_ta[k]  <= TA_W'($signed({1'b0, r_fr2[k]}) * r_a[k]);
            r_t2t[k] <= r_tt[k][2*FRAC_BITS-1 -: FRAC_BITS] * r_fr2[k];
            r_fr4[k] <= r_fr3[k];
            r_b[k]   <= B_W'(r_ta[k] >>> FRAC_BITS) + C10;
            r_t3[k]  <= r_t2t[k][2*FRAC_BITS-1 -: FRAC_BITS];
            r_fr5[k] <= r_fr4[k];
            r_fd5[k] <= FADE_W'((TA_W'($signed({1'b0, r_t3[k]})) * TA_W'(r_b[k]))
                                >>> FRAC_BITS);
            r_fd6[k] <= r_fd5[k];
        end
        r_cell2[0] <= r_prod[0][32 +: TAB_BITS];
        r_cell2[1] <= r_prod[1][32 +: TAB_BITS];
        r_cell2[2] <= r_prod[2][32 +: TAB_BITS];
        r_cell3[0] <= r_cell2[0];
        r_cell3[1] <= r_cell2[1];
        r_cell4    <= r_cell3[0];
    end

    // Hash addresses: level 0 hashes w, level 3 hashes x.
    always_comb begin
        for (int l = 0; l < 4; l++) begin
            for (int r = 0; r < (2 << l); r++) begin
                if (l == 0) begin
                    w_addr[r] = w_lcell[0] + TAB_BITS'(r % 2);
                end else begin
                    w_addr[(2 << l) - 2 + r] = w_lcell[l] + TAB_BITS'(r % 2)
                        + r_hd[(1 << l) - 2 + r / 2][TAB_BITS-1:0];
                end
            end
        end
    end

    // A load writes each level's banks as it passes that level.
    always_comb begin
        for (int l = 0; l < 4; l++) begin
            w_we[l]   = r_ld[l+1] && ({1'b0, r_idx[l+1]} < 9'(TABLE_ENTRIES));
            w_widx[l] = r_idx[l+1][TAB_BITS-1:0];
            w_wval[l] = r_tv[l+1];
        end
    end

    // Permutation table banks, two read ports each.
    for (genvar b = 0; b < NBANK; b++) begin : g_bank
        localparam int BL = $clog2(b + 2) - 1;
        always_ff @(posedge i_clk) begin
            if (w_we[BL]) begin
                r_bank[b][w_widx[BL]] <= w_wval[BL];
            end
            r_hd[2*b]   <= r_bank[b][w_addr[2*b]];
            r_hd[2*b+1] <= r_bank[b][w_addr[2*b+1]];
        end
    end

    // Corner dot products of gradient and offset.
    always_comb begin
        logic signed [D_W-1:0] d;
        logic signed [1:0]     g;
        for (int c = 0; c < 16; c++) begin
            w_dot[c] = '0;
            for (int k = 0; k < 4; k++) begin
                d = $signed({2'b0, r_fr5[k]}) - (((c >> k) & 1) != 0 ? C1 : '0);
                g = grad_comp(r_hd[14 + c][4:0], 2'(k));
                if (g == 2'sd1) begin
                    w_dot[c] = w_dot[c] + VAL_W'(d);
                end else if (g == -2'sd1) begin
                    w_dot[c] = w_dot[c] - VAL_W'(d);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 16; c++) begin
            r_val[c] <= w_dot[c];
        end
    end

    // Blend inputs for each level.
    always_comb begin
        for (int j = 0; j < 16; j++) begin
            w_lin[0][j] = r_val[j];
        end
        for (int l = 1; l < 4; l++) begin
            for (int j = 0; j < 16; j++) begin
                w_lin[l][j] = r_res[l-1][j % 8];
            end
        end
    end

    // Quadrilinear blend, x first and w last, three stages per level.
    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 4; l++) begin
            for (int j = 0; j < (8 >> l); j++) begin
                r_dif[l][j] <= DIFF_W'(w_lin[l][2*j+1]) - DIFF_W'(w_lin[l][2*j]);
                r_lo1[l][j] <= w_lin[l][2*j];
                r_prd[l][j] <= LP_W'(r_fa[l][l] * r_dif[l][j]);
                r_lo2[l][j] <= r_lo1[l][j];
                r_res[l][j] <= r_lo2[l][j] + VAL_W'(r_prd[l][j] >>> FRAC_BITS);
            end
            for (int k = 0; k < 4; k++) begin
                r_fa[l][k] <= (l == 0) ? r_fd6[k] : r_fc[(l == 0) ? 0 : l-1][k];
                r_fb[l][k] <= r_fa[l][k];
                r_fc[l][k] <= r_fb[l][k];
            end
        end
    end

    // Convert to 16 fraction bits and saturate.
    always_comb begin
        w_cv = CV_W'(r_res[3][0]);
        if (FRAC_BITS > 16) begin
            w_cv = (w_cv + CV_W'(1 << (RND_SH - 1))) >>> RND_SH;
        end else if (FRAC_BITS < 16) begin
            w_cv = w_cv <<< UP_SH;
        end
        if (w_cv > CV_W'(OUT_MAX)) begin
            w_sat = OUT_MAX;
        end else if (w_cv < CV_W'(OUT_MIN)) begin
            w_sat = OUT_MIN;
        end else begin
            w_sat = OUT_W'(w_cv);
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= w_sat;
    end

    assign o_valid       = r_out_valid;
    assign o_noise_value = r_out;

endmodule

/* rtl/core/perlin_noise_4d.sv */
// 4D improved Perlin noise: one point per cycle while busy is low.
// The back pipeline holds the scale multiply, four chained table lookup
// levels, dot products and four blend levels of three stages each.
// One request per cycle while busy is low; a table load yields no result.
// Synchronous active-low reset clears the valid chain and sets scale to 1.0.
// Results carry one strobe cycle each; the receiver cannot stall.
`include "assert_macros.svh"
module perlin_noise_4d
    import pn4d_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    i_req_type,
    input  logic [7:0]              i_table_index,
    input  logic [7:0]              i_table_value,
    input  logic signed [31:0]      i_coord_x,
    input  logic signed [31:0]      i_coord_y,
    input  logic signed [31:0]      i_coord_z,
    input  logic signed [31:0]      i_coord_w,
    output logic                    o_valid,
    output logic signed [OUT_W-1:0] o_noise_value,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam logic REG_SCALE = 1'b0;

    logic [SCALE_W-1:0] r_scale;
    logic               w_push;
    t_req               w_freq;
    t_req               w_qreq;
    t_qstat             w_qstat;

    // Configuration register.
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_W'(65536);
        end else if (psel && penable && pwrite && (paddr[2] == REG_SCALE)) begin
            r_scale <= pwdata[SCALE_W-1:0];
        end
    end
    assign prdata = (paddr[2] == REG_SCALE) ? {{(32-SCALE_W){1'b0}}, r_scale} : '0;

    // Front: request intake.
    pn4d_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_req_type    (i_req_type),
        .i_table_index (i_table_index),
        .i_table_value (i_table_value),
        .i_coord_x     (i_coord_x),
        .i_coord_y     (i_coord_y),
        .i_coord_z     (i_coord_z),
        .i_coord_w     (i_coord_w),
        .i_qstat       (w_qstat),
        .o_push        (w_push),
        .o_req         (w_freq)
    );

    // Queue between front and back; the back drains it every cycle.
    pn4d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_req   (w_freq),
        .i_pop   (!w_qstat.empty),
        .o_req   (w_qreq),
        .o_stat  (w_qstat)
    );

    // Back: noise pipeline.
    pn4d_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (!w_qstat.empty),
        .i_req         (w_qreq),
        .i_scale       (r_scale),
        .o_valid       (o_valid),
        .o_noise_value (o_noise_value)
    );

    // Checks on the core's own control.
    `ASSERT_NEXT(a_rst_clears_out, i_clk, !i_rst_n, !o_valid)
    `ASSERT_IMPL(a_q_consistent, i_clk, i_rst_n, 1'b1, !(w_qstat.full && w_qstat.empty))
    `ASSERT_IMPL(a_busy_needs_full, i_clk, i_rst_n, busy, w_qstat.full)

endmodule
